>>> sv/bfpf8_pkg.sv
// Shared constants for the binary frame parser with Fletcher-8 check.
package bfpf8_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [3:0] PH_SYNC1   = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LEN_LO  = 4'd4;
    localparam logic [3:0] PH_LEN_HI  = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CHECK_A = 4'd7;
    localparam logic [3:0] PH_CHECK_B = 4'd8;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_GOOD  = 2'd1;
    localparam logic [1:0] ST_BAD_A = 2'd2;
    localparam logic [1:0] ST_BAD_B = 2'd3;

endpackage

>>> sv/binary_frame_parser_fletcher8_unit.sv
// Binary frame parser with Fletcher-8 check: top level.
// One received byte per beat; every input beat yields exactly one output beat, passed
// from the input register into the result register. Sustained rate is one byte per
// cycle while out_stall is low; the phase/checksum update between them is combinational.
// The input register lets one new byte be accepted while a finished result waits on a
// stalled output. Frames are 0xB5 0x62, class, id, 16-bit length (low byte first),
// payload, check A, check B; class, id and payload come out as message bytes and
// frame_status reports good frame or which check byte failed, on the deciding check byte.
module binary_frame_parser_fletcher8_unit
    import bfpf8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] msg_byte,
    output logic       msg_byte_valid,
    output logic       frame_start,
    output logic [1:0] frame_status
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;

    logic        out_valid_reg;
    logic [7:0]  msg_byte_reg, msg_byte_next;
    logic        msg_valid_reg, msg_valid_next;
    logic        start_reg, start_next;
    logic [1:0]  status_reg, status_next;

    logic        advance;
    logic        fire;
    logic        add_sums;
    logic [7:0]  sum_a_add;
    logic [15:0] len_full;
    logic [15:0] remaining_dec;

    // result register is free or being drained this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    assign sum_a_add     = sum_a_reg + in_byte_reg;
    assign len_full      = {in_byte_reg, remaining_reg[7:0]};
    assign remaining_dec = remaining_reg - 16'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        add_sums       = 1'b0;
        msg_valid_next = 1'b0;
        start_next     = 1'b0;
        status_next    = ST_NONE;
        unique case (phase_reg)
            PH_SYNC1:
            begin
                if (in_byte_reg == SYNC_FIRST)
                begin
                    remaining_next = 16'd0;
                    phase_next     = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                phase_next = (in_byte_reg == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS:
            begin
                msg_valid_next = 1'b1;
                start_next     = 1'b1;
                add_sums       = 1'b1;
                phase_next     = PH_ID;
            end
            PH_ID:
            begin
                msg_valid_next = 1'b1;
                add_sums       = 1'b1;
                phase_next     = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                remaining_next = {8'd0, in_byte_reg};
                add_sums       = 1'b1;
                phase_next     = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                remaining_next = len_full;
                add_sums       = 1'b1;
                phase_next     = (len_full != 16'd0) ? PH_PAYLOAD : PH_CHECK_A;
            end
            PH_PAYLOAD:
            begin
                msg_valid_next = 1'b1;
                add_sums       = 1'b1;
                remaining_next = remaining_dec;
                if (remaining_dec == 16'd0)
                begin
                    phase_next = PH_CHECK_A;
                end
            end
            PH_CHECK_A:
            begin
                if (in_byte_reg == sum_a_reg)
                begin
                    phase_next = PH_CHECK_B;
                end
                else
                begin
                    status_next = ST_BAD_A;
                    phase_next  = PH_SYNC1;
                end
            end
            PH_CHECK_B:
            begin
                status_next = (in_byte_reg == sum_b_reg) ? ST_GOOD : ST_BAD_B;
                phase_next  = PH_SYNC1;
            end
            default:
            begin
                phase_next = PH_SYNC1;
            end
        endcase

        // sums restart on a first sync byte
        if (phase_reg == PH_SYNC1 && in_byte_reg == SYNC_FIRST)
        begin
            sum_a_next = 8'd0;
            sum_b_next = 8'd0;
        end
        else if (add_sums)
        begin
            sum_a_next = sum_a_add;
            sum_b_next = sum_b_reg + sum_a_add;
        end
        else
        begin
            sum_a_next = sum_a_reg;
            sum_b_next = sum_b_reg;
        end

        msg_byte_next = msg_valid_next ? in_byte_reg : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SYNC1;
            remaining_reg <= 16'd0;
            sum_a_reg     <= 8'd0;
            sum_b_reg     <= 8'd0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                phase_reg     <= phase_next;
                remaining_reg <= remaining_next;
                sum_a_reg     <= sum_a_next;
                sum_b_reg     <= sum_b_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
        if (fire)
        begin
            msg_byte_reg  <= msg_byte_next;
            msg_valid_reg <= msg_valid_next;
            start_reg     <= start_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign msg_byte       = msg_byte_reg;
    assign msg_byte_valid = msg_valid_reg;
    assign frame_start    = start_reg;
    assign frame_status   = status_reg;

endmodule

>>> sv/bfpf8_checker.sv
// Port-level checks for the binary frame parser, bound to the top level.
module bfpf8_checker
    import bfpf8_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] msg_byte,
    input logic       msg_byte_valid,
    input logic       frame_start,
    input logic [1:0] frame_status
);

    // class beat is always a message byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_start) |-> msg_byte_valid)
        else $error("frame_start without msg_byte_valid");

    // non-message beats carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !msg_byte_valid) |-> (msg_byte == 8'd0))
        else $error("msg_byte nonzero on non-message beat");

    // status only on check bytes, never on message bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_status != ST_NONE) |-> !msg_byte_valid)
        else $error("frame_status on a message beat");

    // stalled result stays presented
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("out_valid dropped while stalled");

    // stalled input beat is held by the sender
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> (in_valid && $stable(rx_byte)))
        else $error("input beat changed while stalled");

endmodule

bind binary_frame_parser_fletcher8_unit bfpf8_checker u_bfpf8_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .msg_byte       (msg_byte),
    .msg_byte_valid (msg_byte_valid),
    .frame_start    (frame_start),
    .frame_status   (frame_status)
);
